[hdl/lmc_pkg.sv]
package lmc_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PIX_W = 8;

   localparam int SEL_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int WIDTH_RESET = 1024;
   localparam int HEIGHT_RESET = 1024;

   localparam int COL_DEPTH = 4;
   localparam int COL_PTR_W = $clog2(COL_DEPTH);
   localparam int COL_CNT_W = $clog2(COL_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASK_SELECT  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      VEC_L,
      VEC_E,
      VEC_S
   } vec_type;

   typedef struct packed {
      vec_type col_vec;
      vec_type row_vec;
   } mask_type;

   localparam int MASK_COUNT = 9;
   localparam int MASK_LAST = MASK_COUNT - 1;

   localparam mask_type MASK_TABLE [MASK_COUNT] = '{
      '{VEC_L, VEC_L}, '{VEC_L, VEC_E}, '{VEC_L, VEC_S},
      '{VEC_E, VEC_L}, '{VEC_E, VEC_E}, '{VEC_E, VEC_S},
      '{VEC_S, VEC_L}, '{VEC_S, VEC_E}, '{VEC_S, VEC_S}
   };

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             start_of_frame;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] response;
      logic             clipped;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
   } geom_type;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bottom;
      logic             emit;
      logic             frame_end;
   } col_type;

   typedef struct packed {
      logic                 empty;
      logic [COL_CNT_W-1:0] count;
   } col_q_status_type;

   function automatic mask_type decode_mask(input logic [SEL_W-1:0] sel);
      mask_type m;
      if (sel > SEL_W'(MASK_LAST)) begin
         m = MASK_TABLE[MASK_LAST];
      end else begin
         m = MASK_TABLE[sel];
      end
      return m;
   endfunction

endpackage

[hdl/lmc_front.sv]
module lmc_front import lmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   input  geom_type         geom,
   input  col_q_status_type q_status,
   output logic             col_push,
   output col_type          col_data
);

   logic [COL_W-1:0]     col_ff, col_in, cur_col;
   logic [ROW_W-1:0]     row_ff, row_in, cur_row;
   logic                 accept;
   logic [COL_CNT_W:0]   occupancy;

   logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]   rd_data_ff;
   logic [2*PIX_W-1:0]   wr_data;
   logic [2*PIX_W-1:0]   f1_entry;

   logic                 f1_valid_ff;
   logic [COL_W-1:0]     f1_addr_ff;
   logic [PIX_W-1:0]     f1_pixel_ff;
   logic                 f1_emit_ff;
   logic                 f1_frame_end_ff;
   logic                 fwd_ff;
   logic [2*PIX_W-1:0]   fwd_data_ff;

   assign occupancy = {1'b0, q_status.count} + {{COL_CNT_W{1'b0}}, f1_valid_ff};
   assign req_full  = occupancy >= (COL_CNT_W+1)'(COL_DEPTH);
   assign accept    = req_push && !req_full;

   assign cur_col = req_data.start_of_frame ? '0 : col_ff;
   assign cur_row = req_data.start_of_frame ? '0 : row_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (cur_col >= geom.last_col) begin
            col_in = '0;
            row_in = (cur_row >= geom.last_row) ? '0 : cur_row + ROW_W'(1);
         end else begin
            col_in = cur_col + COL_W'(1);
            row_in = cur_row;
         end
      end
   end

   // The entry holds the row two above in the high byte and the row above in the low byte.
   assign f1_entry = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_data  = {f1_entry[PIX_W-1:0], f1_pixel_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[cur_col];
      end
      if (f1_valid_ff) begin
         line_mem[f1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= accept;
         if (accept) begin
            fwd_ff <= f1_valid_ff && (f1_addr_ff == cur_col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_addr_ff      <= cur_col;
         f1_pixel_ff     <= req_data.pixel;
         f1_emit_ff      <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
         f1_frame_end_ff <= (cur_row >= geom.last_row) && (cur_col >= geom.last_col);
         fwd_data_ff     <= wr_data;
      end
   end

   assign col_push = f1_valid_ff;
   assign col_data = '{top:       f1_entry[2*PIX_W-1:PIX_W],
                       mid:       f1_entry[PIX_W-1:0],
                       bottom:    f1_pixel_ff,
                       emit:      f1_emit_ff,
                       frame_end: f1_frame_end_ff};

endmodule

[hdl/lmc_col_queue.sv]
module lmc_col_queue import lmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  col_type          push_data,
   input  logic             pop,
   output col_type          pop_data,
   output col_q_status_type status
);

   col_type              entry_ff [COL_DEPTH];
   logic [COL_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [COL_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == COL_PTR_W'(COL_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + COL_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == COL_PTR_W'(COL_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + COL_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + COL_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COL_CNT_W'(1);
         end
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

`ifndef NO_ASSERTIONS
   a_col_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < COL_CNT_W'(COL_DEPTH)) || pop)
      else $error("Column queue written while full.");
`endif

endmodule

[hdl/lmc_back.sv]
module lmc_back import lmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mask_type         mask,
   input  col_q_status_type q_status,
   output logic             col_pop,
   input  col_type          col_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   localparam int SUM_W = 13;
   localparam int MAG_W = SUM_W - 1;
   localparam int QRT_W = MAG_W - 2;
   localparam int DIV3_RECIP = 2731;
   localparam int DIV3_SHIFT = 13;
   localparam int RECIP_W = 12;
   localparam int PROD_W = QRT_W + RECIP_W;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   function automatic logic signed [SUM_W-1:0] apply_vec(
      input vec_type                 v,
      input logic signed [SUM_W-1:0] x0,
      input logic signed [SUM_W-1:0] x1,
      input logic signed [SUM_W-1:0] x2
   );
      logic signed [SUM_W-1:0] r;
      case (v)
         VEC_L:   r = x0 + (x1 <<< 1) + x2;
         VEC_E:   r = x2 - x0;
         VEC_S:   r = (x1 <<< 1) - x0 - x2;
         default: r = '0;
      endcase
      return r;
   endfunction

   logic [PIX_W-1:0]        win_old_ff [3];
   logic [PIX_W-1:0]        win_mid_ff [3];
   logic [PIX_W-1:0]        win_new [3];
   logic signed [SUM_W-1:0] row_sum [3];
   logic signed [SUM_W-1:0] sum;

   logic                    b1_valid_ff, b1_emit_ff, b1_frame_end_ff;
   logic signed [SUM_W-1:0] b1_sum_ff;

   logic [MAG_W-1:0]        mag;
   logic [QRT_W-1:0]        quarter;
   logic [PROD_W-1:0]       prod;
   logic [MAG_W+1:0]        triple;
   logic [MAG_W-1:0]        quot;
   logic                    clip;

   logic                    b2_valid_ff, b2_emit_ff;
   rsp_type                 b2_rsp_ff;

   rsp_type                 out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]    out_wr_ptr_ff, out_rd_ptr_ff;
   logic [OUT_CNT_W-1:0]    out_count_ff;
   logic [OUT_CNT_W:0]      credit_used;
   logic                    out_push, out_pop;

   assign credit_used = {1'b0, out_count_ff} + {{OUT_CNT_W{1'b0}}, b1_valid_ff}
                        + {{OUT_CNT_W{1'b0}}, b2_valid_ff};
   assign col_pop = !q_status.empty && (credit_used < (OUT_CNT_W+1)'(OUT_DEPTH));

   assign win_new[0] = col_data.top;
   assign win_new[1] = col_data.mid;
   assign win_new[2] = col_data.bottom;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_sum[k] = apply_vec(mask.row_vec,
                                $signed({{(SUM_W-PIX_W){1'b0}}, win_old_ff[k]}),
                                $signed({{(SUM_W-PIX_W){1'b0}}, win_mid_ff[k]}),
                                $signed({{(SUM_W-PIX_W){1'b0}}, win_new[k]}));
      end
      sum = apply_vec(mask.col_vec, row_sum[0], row_sum[1], row_sum[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            win_old_ff[k] <= '0;
            win_mid_ff[k] <= '0;
         end
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         if (col_pop) begin
            for (int k = 0; k < 3; k++) begin
               win_old_ff[k] <= win_mid_ff[k];
               win_mid_ff[k] <= win_new[k];
            end
         end
         b1_valid_ff <= col_pop;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (col_pop) begin
         b1_sum_ff       <= sum;
         b1_emit_ff      <= col_data.emit;
         b1_frame_end_ff <= col_data.frame_end;
      end
   end

   // Three times the magnitude over the divisor: magnitude/12, magnitude/4 or 3*magnitude/4.
   // Division by three uses a reciprocal that is exact over the whole quarter range.
   always_comb begin
      mag     = b1_sum_ff[SUM_W-1] ? MAG_W'(-b1_sum_ff) : MAG_W'(b1_sum_ff);
      quarter = mag[MAG_W-1:2];
      prod    = {{RECIP_W{1'b0}}, quarter} * PROD_W'(DIV3_RECIP);
      triple  = {1'b0, mag, 1'b0} + {2'b00, mag};
      if (mask.col_vec == VEC_L && mask.row_vec == VEC_L) begin
         quot = MAG_W'(prod[PROD_W-1:DIV3_SHIFT]);
      end else if (mask.col_vec == VEC_L || mask.row_vec == VEC_L) begin
         quot = {2'b00, quarter};
      end else begin
         quot = triple[MAG_W+1:2];
      end
      clip = quot > MAG_W'(255);
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff) begin
         b2_emit_ff          <= b1_emit_ff;
         b2_rsp_ff.response  <= clip ? '1 : quot[PIX_W-1:0];
         b2_rsp_ff.clipped   <= clip;
         b2_rsp_ff.frame_end <= b1_frame_end_ff;
      end
   end

   assign out_push = b2_valid_ff && b2_emit_ff;
   assign out_pop  = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ptr_ff] <= b2_rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         if (out_push) begin
            out_wr_ptr_ff <= (out_wr_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                             : out_wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (out_pop) begin
            out_rd_ptr_ff <= (out_rd_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                             : out_rd_ptr_ff + OUT_PTR_W'(1);
         end
         if (out_push && !out_pop) begin
            out_count_ff <= out_count_ff + OUT_CNT_W'(1);
         end else if (out_pop && !out_push) begin
            out_count_ff <= out_count_ff - OUT_CNT_W'(1);
         end
      end
   end

   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_ff[out_rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_out_no_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count_ff < OUT_CNT_W'(OUT_DEPTH)) || out_pop)
      else $error("Result queue written while full.");

   a_stage_follows_pop : assert property (@(posedge clock) disable iff (reset)
      b1_valid_ff |-> $past(col_pop))
      else $error("Sum stage valid without a column transfer.");

   a_clip_saturates : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.clipped) |-> (rsp_data.response == '1))
      else $error("Clipped result is not saturated.");
`endif

endmodule

[hdl/laws_mask_convolution_3x3.sv]
// Laws 3x3 texture mask filter for 8-bit grey pixels in raster order. It sustains one pixel
// per clock while neither queue is full: the front end reads and then rewrites the line stores
// at each pixel's column, and four-entry column and result queues let either side stall without
// losing a transfer. A result passes the front-end register, column queue, sum and scaling
// registers and result queue after the pixel that completes its window is accepted; only windows
// wholly inside the image produce one, and frame_end marks the result of the last pixel of the
// image. The line stores are not cleared after reset, so the first two rows of a frame only fill
// them. Write the configuration registers only while no transfer is in progress.
module laws_mask_convolution_3x3 import lmc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [SEL_W-1:0]      mask_select_ff;
   logic [CSR_DATA_W-1:0] image_width_ff;
   logic [CSR_DATA_W-1:0] image_height_ff;

   geom_type              geom;
   mask_type              mask;
   logic                  col_push, col_pop;
   col_type               col_push_data, col_pop_data;
   col_q_status_type      q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_select_ff  <= '0;
         image_width_ff  <= CSR_DATA_W'(WIDTH_RESET);
         image_height_ff <= CSR_DATA_W'(HEIGHT_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MASK_SELECT:  mask_select_ff  <= csr_wdata[SEL_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (image_width_ff < CSR_DATA_W'(3)) begin
         geom.last_col = COL_W'(2);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         geom.last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         geom.last_col = COL_W'(image_width_ff - CSR_DATA_W'(1));
      end
      if (image_height_ff < CSR_DATA_W'(3)) begin
         geom.last_row = ROW_W'(2);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         geom.last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         geom.last_row = ROW_W'(image_height_ff - CSR_DATA_W'(1));
      end
   end

   assign mask = decode_mask(mask_select_ff);

   lmc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .geom     (geom),
      .q_status (q_status),
      .col_push (col_push),
      .col_data (col_push_data)
   );

   lmc_col_queue u_col_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (col_push),
      .push_data (col_push_data),
      .pop       (col_pop),
      .pop_data  (col_pop_data),
      .status    (q_status)
   );

   lmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mask      (mask),
      .q_status  (q_status),
      .col_pop   (col_pop),
      .col_data  (col_pop_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
